// ===== rtl/maac_pkg.sv =====
// Shared constants, codes and types of the motion-aware alarm controller.
`timescale 1ns / 1ps

package maac_pkg;

    // Operation codes of an input beat.
    localparam logic [1:0] OP_TICK   = 2'd0;
    localparam logic [1:0] OP_SAMPLE = 2'd1;
    localparam logic [1:0] OP_BUTTON = 2'd2;
    localparam logic [1:0] OP_STOP   = 2'd3;

    // Alarm modes.
    localparam logic [1:0] MODE_DISABLED = 2'd0;
    localparam logic [1:0] MODE_ENABLED  = 2'd1;
    localparam logic [1:0] MODE_SOFT     = 2'd2;
    localparam logic [1:0] MODE_RINGING  = 2'd3;

    // Configuration register indexes (byte address is four times the index).
    localparam logic [1:0] REG_ALARM_HOUR   = 2'd0;
    localparam logic [1:0] REG_ALARM_MINUTE = 2'd1;
    localparam logic [1:0] REG_SOFT_LEN     = 2'd2;

    // Register reset values.
    localparam logic [4:0] ALARM_HOUR_RST   = 5'd8;
    localparam logic [5:0] ALARM_MINUTE_RST = 6'd30;
    localparam logic [5:0] SOFT_LEN_RST     = 6'd30;

    // Clock arithmetic.
    localparam logic [4:0] LAST_HOUR       = 5'd23;
    localparam logic [7:0] MINUTES_PER_HOUR = 8'd60;

    // Divide by ten as a multiply by ceil(2^16 / 10) and a 16-bit shift;
    // exact for magnitudes up to 2^13.
    localparam logic [13:0] DIV10_RECIP = 14'd6554;
    localparam int          DIV10_SHIFT = 16;

    // Motion detection thresholds.
    localparam logic [15:0] MOTION_THRESHOLD = 16'd100;
    localparam logic [7:0]  COUNT_MAX        = 8'd255;
    localparam logic [7:0]  COUNT_TRIGGER    = 8'd5;

    // Acceleration after scaling to units of ten milli-g.
    typedef logic signed [10:0] t_accel;

    // Motion unit verdict for one sample.
    typedef struct packed {
        logic moved;    // low 16 bits of the sum of squared changes above the threshold
    } t_motion;

endpackage

// ===== rtl/motion_aware_alarm_controller.sv =====
// Top level of the motion-aware alarm controller: input register, mode logic, result.
`timescale 1ns / 1ps

// Every input beat (second tick, accelerometer sample, mode button or stop)
// yields exactly one result beat carrying the mode, the wake-window flag and
// the motion counter as they stand after that beat. A beat is captured in an
// input register, where the three axes have already been divided by ten;
// from there the mode logic and the motion unit (three 12-bit squarers and a
// sum) update the state registers, which are the result register itself,
// once that register can take the new result. A new beat is taken in every
// cycle as long as the result side is not stalling; a held result only stops
// the pipeline once the input register is full too. The alarm time and soft
// length sit behind an APB-style port at byte addresses 0, 4 and 8 and are
// meant to be written while no beat is in flight.
module motion_aware_alarm_controller (
    input  logic               i_clk,
    input  logic               i_rst_n,

    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,

    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_operation,
    input  logic [4:0]         i_now_hour,
    input  logic [5:0]         i_now_minute,
    input  logic signed [13:0] i_accel_x,
    input  logic signed [13:0] i_accel_y,
    input  logic signed [13:0] i_accel_z,

    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [1:0]         o_mode,
    output logic               o_window_open,
    output logic [7:0]         o_motion_count
);

    // Configuration registers.
    logic [4:0] r_alarm_hour;
    logic [5:0] r_alarm_minute;
    logic [5:0] r_soft_len;

    // Input register.
    logic                r_in_valid;
    logic [1:0]          r_op;
    logic [4:0]          r_hour;
    logic [5:0]          r_minute;
    maac_pkg::t_accel    r_sx, r_sy, r_sz;

    // Controller state; mode, window and counter double as the result register.
    logic             r_out_valid;
    logic [1:0]       r_mode;
    logic             r_window;
    logic [7:0]       r_count;
    logic             r_rts;
    maac_pkg::t_accel r_prev_x, r_prev_y, r_prev_z;

    logic [1:0]       n_mode;
    logic             n_window;
    logic [7:0]       n_count;
    logic             n_rts;

    maac_pkg::t_accel  scaled_x, scaled_y, scaled_z;
    maac_pkg::t_motion motion;

    logic       advance;
    logic       load;
    logic       cfg_write;
    logic [4:0] start_hour;
    logic [7:0] start_minute;
    logic       start_hit;
    logic       alarm_hit;
    logic       win;
    logic [1:0] reg_index;

    // ------------------------------------------------------------------
    // Configuration port. The register index is the word address.
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign reg_index = paddr[3:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alarm_hour   <= maac_pkg::ALARM_HOUR_RST;
            r_alarm_minute <= maac_pkg::ALARM_MINUTE_RST;
            r_soft_len     <= maac_pkg::SOFT_LEN_RST;
        end else if (cfg_write) begin
            case (reg_index)
                maac_pkg::REG_ALARM_HOUR:   r_alarm_hour   <= pwdata[4:0];
                maac_pkg::REG_ALARM_MINUTE: r_alarm_minute <= pwdata[5:0];
                maac_pkg::REG_SOFT_LEN:     r_soft_len     <= pwdata[5:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_index)
            maac_pkg::REG_ALARM_HOUR:   prdata = {27'd0, r_alarm_hour};
            maac_pkg::REG_ALARM_MINUTE: prdata = {26'd0, r_alarm_minute};
            maac_pkg::REG_SOFT_LEN:     prdata = {26'd0, r_soft_len};
            default:                    prdata = 32'd0;
        endcase
    end

    // ------------------------------------------------------------------
    // Handshake. The state only moves when the result register can take
    // the new result, i.e. it is empty or its beat is leaving now.
    // ------------------------------------------------------------------
    assign advance     = !r_out_valid || !i_out_stall;
    assign o_in_stall  = r_in_valid && !advance;
    assign load        = !o_in_stall;
    assign o_out_valid = r_out_valid;

    // Axes are scaled on the way into the input register.
    maac_scale u_scale_x (.i_accel(i_accel_x), .o_scaled(scaled_x));
    maac_scale u_scale_y (.i_accel(i_accel_y), .o_scaled(scaled_y));
    maac_scale u_scale_z (.i_accel(i_accel_z), .o_scaled(scaled_z));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (load) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && i_in_valid) begin
            r_op     <= i_operation;
            r_hour   <= i_now_hour;
            r_minute <= i_now_minute;
            r_sx     <= scaled_x;
            r_sy     <= scaled_y;
            r_sz     <= scaled_z;
        end
    end

    maac_motion u_motion (
        .i_cur_x  (r_sx),
        .i_cur_y  (r_sy),
        .i_cur_z  (r_sz),
        .i_prev_x (r_prev_x),
        .i_prev_y (r_prev_y),
        .i_prev_z (r_prev_z),
        .o_motion (motion)
    );

    // ------------------------------------------------------------------
    // Window start time: alarm time less soft_len minutes. When the
    // subtraction borrows, the hour steps back (midnight wraps to 23) and
    // the minute is taken modulo 256, so a negative start never matches.
    // ------------------------------------------------------------------
    always_comb begin
        if (r_alarm_minute >= r_soft_len) begin
            start_hour   = r_alarm_hour;
            start_minute = 8'(r_alarm_minute - r_soft_len);
        end else begin
            start_hour   = (r_alarm_hour != 5'd0) ? 5'(r_alarm_hour - 5'd1)
                                                  : maac_pkg::LAST_HOUR;
            start_minute = 8'(maac_pkg::MINUTES_PER_HOUR - 8'(r_soft_len)
                              + 8'(r_alarm_minute));
        end
        start_hit = (8'(r_minute) == start_minute) && (r_hour == start_hour);
        alarm_hit = (r_minute == r_alarm_minute) && (r_hour == r_alarm_hour);
    end

    // ------------------------------------------------------------------
    // Mode logic for the beat in the input register.
    // ------------------------------------------------------------------
    always_comb begin
        n_mode   = r_mode;
        n_window = r_window;
        n_count  = r_count;
        n_rts    = r_rts;
        win      = r_window;
        case (r_op)
            maac_pkg::OP_TICK: begin
                if (r_mode == maac_pkg::MODE_ENABLED) begin
                    if (alarm_hit) begin
                        n_mode   = maac_pkg::MODE_RINGING;
                        n_window = 1'b0;
                        n_rts    = 1'b1;
                    end
                end else if (r_mode == maac_pkg::MODE_SOFT) begin
                    // The window opening clears the counter, so the motion
                    // trigger below cannot fire on that same tick.
                    if (start_hit) begin
                        win     = 1'b1;
                        n_count = 8'd0;
                    end
                    if (alarm_hit) begin
                        n_rts = 1'b1;
                        if (win) begin
                            n_mode = maac_pkg::MODE_RINGING;
                        end
                        win = 1'b0;
                    end
                    if (win && (n_count > maac_pkg::COUNT_TRIGGER)) begin
                        n_rts  = 1'b1;
                        n_mode = maac_pkg::MODE_RINGING;
                        win    = 1'b0;
                    end
                    n_window = win;
                end
            end
            maac_pkg::OP_SAMPLE: begin
                if (r_window) begin
                    if (motion.moved) begin
                        if (r_count != maac_pkg::COUNT_MAX) begin
                            n_count = 8'(r_count + 8'd1);
                        end
                    end else if (r_count != 8'd0) begin
                        n_count = 8'(r_count - 8'd1);
                    end
                end
            end
            maac_pkg::OP_BUTTON: begin
                // The button cycles disabled, enabled, soft; ringing ignores it.
                case (r_mode)
                    maac_pkg::MODE_DISABLED: begin
                        n_mode   = maac_pkg::MODE_ENABLED;
                        n_window = 1'b0;
                    end
                    maac_pkg::MODE_ENABLED: begin
                        n_mode   = maac_pkg::MODE_SOFT;
                        n_window = 1'b0;
                    end
                    maac_pkg::MODE_SOFT: begin
                        n_mode   = maac_pkg::MODE_DISABLED;
                        n_window = 1'b0;
                    end
                    default: ;
                endcase
            end
            maac_pkg::OP_STOP: begin
                if (r_mode == maac_pkg::MODE_RINGING) begin
                    if (r_rts) begin
                        n_rts  = 1'b0;
                        n_mode = maac_pkg::MODE_SOFT;
                    end else begin
                        n_mode = maac_pkg::MODE_ENABLED;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_mode      <= maac_pkg::MODE_DISABLED;
            r_window    <= 1'b0;
            r_count     <= 8'd0;
            r_rts       <= 1'b0;
            r_prev_x    <= '0;
            r_prev_y    <= '0;
            r_prev_z    <= '0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
            if (r_in_valid) begin
                r_mode   <= n_mode;
                r_window <= n_window;
                r_count  <= n_count;
                r_rts    <= n_rts;
                // Previous sample is only kept while the window is open.
                if ((r_op == maac_pkg::OP_SAMPLE) && r_window) begin
                    r_prev_x <= r_sx;
                    r_prev_y <= r_sy;
                    r_prev_z <= r_sz;
                end
            end
        end
    end

    assign o_mode         = r_mode;
    assign o_window_open  = r_window;
    assign o_motion_count = r_count;

endmodule

// ===== rtl/maac_scale.sv =====
// Signed divide by ten, truncating toward zero, of one accelerometer axis.
`timescale 1ns / 1ps

module maac_scale (
    input  logic signed [13:0] i_accel,
    output maac_pkg::t_accel   o_scaled
);

    logic [13:0] mag;
    logic [27:0] prod;
    logic [9:0]  quot;

    always_comb begin
        mag  = i_accel[13] ? 14'(-i_accel) : 14'(i_accel);
        prod = 28'(mag) * 28'(maac_pkg::DIV10_RECIP);
        quot = prod[maac_pkg::DIV10_SHIFT +: 10];
        o_scaled = i_accel[13] ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
    end

endmodule

// ===== rtl/maac_motion.sv =====
// Sum of squared changes between two scaled samples, compared with the threshold.
`timescale 1ns / 1ps

module maac_motion (
    input  maac_pkg::t_accel i_cur_x,
    input  maac_pkg::t_accel i_cur_y,
    input  maac_pkg::t_accel i_cur_z,
    input  maac_pkg::t_accel i_prev_x,
    input  maac_pkg::t_accel i_prev_y,
    input  maac_pkg::t_accel i_prev_z,
    output maac_pkg::t_motion o_motion
);

    logic signed [11:0] dx, dy, dz;
    logic signed [23:0] sx, sy, sz;
    logic        [23:0] acc;

    always_comb begin
        dx  = 12'(i_cur_x) - 12'(i_prev_x);
        dy  = 12'(i_cur_y) - 12'(i_prev_y);
        dz  = 12'(i_cur_z) - 12'(i_prev_z);
        sx  = 24'(dx) * 24'(dx);
        sy  = 24'(dy) * 24'(dy);
        sz  = 24'(dz) * 24'(dz);
        acc = 24'(sx) + 24'(sy) + 24'(sz);
        // Only the low 16 bits of the sum take part in the compare.
        o_motion.moved = acc[15:0] > maac_pkg::MOTION_THRESHOLD;
    end

endmodule
